@@ rtl/bdq_pkg.sv @@
package bdq_pkg;

  localparam int DEPTH = 16;
  localparam int WIDTH = 32;

  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CAP_W   = 5;
  localparam int VALUE_W = 32;
  localparam int FILL_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [1:0] {
    FN_PUSH_REAR  = 2'd0,
    FN_POP_FRONT  = 2'd1,
    FN_PUSH_FRONT = 2'd2,
    FN_POP_REAR   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic accept;
    logic load_pop;
  } dp_cmd_t;

  typedef struct packed {
    logic pop_ok;
  } dp_stat_t;

endpackage

@@ rtl/bdq_if.sv @@
interface bdq_in_if;
  import bdq_pkg::*;

  logic                       valid;
  logic                       ready;
  func_t                      func;
  logic signed [VALUE_W-1:0]  push_value;

  modport source (output valid, output func, output push_value, input ready);
  modport sink (input valid, input func, input push_value, output ready);
endinterface

interface bdq_out_if;
  import bdq_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  pop_value;
  status_t                    status;
  logic [FILL_W-1:0]          fill_count;

  modport source (output valid, output pop_value, output status, output fill_count,
                  input ready);
  modport sink (input valid, input pop_value, input status, input fill_count,
                output ready);
endinterface

@@ rtl/bdq_ram.sv @@
module bdq_ram #(
  parameter int W = 32,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/bdq_ctrl.sv @@
module bdq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  bdq_pkg::dp_stat_t stat,
  output bdq_pkg::dp_cmd_t  cmd
);
  import bdq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  assign cmd.accept   = accept;
  assign cmd.load_pop = (state_r == S_READ);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && stat.pop_ok) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if ((accept && !stat.pop_ok) || (state_r == S_READ)) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/bdq_dp.sv @@
module bdq_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [bdq_pkg::CAP_W-1:0]          cfg_wdata,
  input  bdq_pkg::func_t                     func,
  input  logic signed [bdq_pkg::VALUE_W-1:0] push_value,
  input  bdq_pkg::dp_cmd_t                   cmd,
  output bdq_pkg::dp_stat_t                  stat,
  output logic signed [bdq_pkg::VALUE_W-1:0] pop_value,
  output bdq_pkg::status_t                   status,
  output logic [bdq_pkg::FILL_W-1:0]         fill_count
);
  import bdq_pkg::*;

  logic [CAP_W-1:0]          cap_r;
  logic [ADDR_W-1:0]         head_r, head_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic signed [VALUE_W-1:0] pop_value_r;
  status_t                   status_r, status_nxt;
  logic [FILL_W-1:0]         fill_r;

  logic [31:0]               eff_cap;
  logic                      is_full;
  logic                      is_empty;
  logic [ADDR_W-1:0]         head_dec;
  logic [ADDR_W-1:0]         head_inc;
  logic [CNT_W:0]            rear_sum;
  logic [CNT_W:0]            last_sum;
  logic [ADDR_W-1:0]         rear_pos;
  logic [ADDR_W-1:0]         last_pos;

  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_waddr;
  logic [ADDR_W-1:0]         ram_raddr;
  logic [WIDTH-1:0]          ram_wdata;
  logic [WIDTH-1:0]          ram_rdata;

  always_comb begin
    eff_cap = 32'(cap_r);
    if (eff_cap == 32'd0) begin
      eff_cap = 32'd1;
    end
    if (eff_cap > 32'(DEPTH)) begin
      eff_cap = 32'(DEPTH);
    end
  end

  assign is_full  = (32'(count_r) >= eff_cap);
  assign is_empty = (count_r == '0);

  assign head_dec = (head_r == '0) ? ADDR_W'(DEPTH - 1) : head_r - 1'b1;
  assign head_inc = (head_r == ADDR_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;

  assign rear_sum = (CNT_W+1)'(head_r) + (CNT_W+1)'(count_r);
  assign last_sum = rear_sum - 1'b1;
  assign rear_pos = (rear_sum >= (CNT_W+1)'(DEPTH)) ?
                    ADDR_W'(rear_sum - (CNT_W+1)'(DEPTH)) : ADDR_W'(rear_sum);
  assign last_pos = (last_sum >= (CNT_W+1)'(DEPTH)) ?
                    ADDR_W'(last_sum - (CNT_W+1)'(DEPTH)) : ADDR_W'(last_sum);

  assign ram_wdata = WIDTH'(push_value);

  always_comb begin
    head_nxt    = head_r;
    count_nxt   = count_r;
    status_nxt  = ST_OK;
    ram_we      = 1'b0;
    ram_waddr   = rear_pos;
    ram_raddr   = head_r;
    stat.pop_ok = 1'b0;
    unique case (func)
      FN_PUSH_REAR: begin
        if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          ram_we    = cmd.accept;
          ram_waddr = rear_pos;
          count_nxt = count_r + 1'b1;
        end
      end
      FN_PUSH_FRONT: begin
        if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          ram_we    = cmd.accept;
          ram_waddr = head_dec;
          head_nxt  = head_dec;
          count_nxt = count_r + 1'b1;
        end
      end
      FN_POP_FRONT: begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          stat.pop_ok = 1'b1;
          ram_raddr   = head_r;
          head_nxt    = head_inc;
          count_nxt   = count_r - 1'b1;
        end
      end
      FN_POP_REAR: begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          stat.pop_ok = 1'b1;
          ram_raddr   = last_pos;
          count_nxt   = count_r - 1'b1;
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  bdq_ram #(
    .W (WIDTH),
    .D (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (cmd.accept) begin
        head_r  <= head_nxt;
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      status_r    <= status_nxt;
      fill_r      <= FILL_W'(count_nxt);
      pop_value_r <= '0;
    end else if (cmd.load_pop) begin
      pop_value_r <= VALUE_W'(signed'(ram_rdata));
    end
  end

  assign pop_value  = pop_value_r;
  assign status     = status_r;
  assign fill_count = fill_r;

endmodule

@@ rtl/bounded_deque_unit.sv @@
// Bounded double-ended queue of signed words.
// The input channel carries one word per operation: func selects push rear,
// pop front, push front or pop rear, and push_value is the word to push.
// The result channel returns one word per operation: the popped value (zero
// for a push or a refused pop), a status of ok, full or empty, and the fill
// count after the operation.
// The capacity register is written through cfg_we and cfg_wdata; the user
// must write it only while the block is idle, as the block does not enforce
// this. Zero acts as one and values above the depth act as the depth.
// The result of a push or a refused pop is valid the cycle after acceptance.
// A successful pop first reads the store, which has a registered read port,
// and then loads the pop value register; the input stays not ready meanwhile.
// A new word is taken in the same cycle that a waiting result is taken.
// If the receiver stalls, the result is held and the input stays not ready.
// Reset empties the queue and sets the capacity to sixteen; the store itself
// is not cleared.
module bounded_deque_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [bdq_pkg::CAP_W-1:0] cfg_wdata,
  bdq_in_if.sink                    in_ch,
  bdq_out_if.source                 out_ch
);
  import bdq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bdq_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .func       (in_ch.func),
    .push_value (in_ch.push_value),
    .cmd        (cmd),
    .stat       (stat),
    .pop_value  (out_ch.pop_value),
    .status     (out_ch.status),
    .fill_count (out_ch.fill_count)
  );

endmodule
